### sv/quad_float_scale_by_power_of_two_macros.svh
// Assertion macros for the binary128 scale block.
`ifndef QUAD_FLOAT_SCALE_BY_POWER_OF_TWO_MACROS_SVH
`define QUAD_FLOAT_SCALE_BY_POWER_OF_TWO_MACROS_SVH
`ifndef SYNTHESIS
`define QFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QFS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define QFS_ASSERT(label, clk, rst_n, prop, msg)
`define QFS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

### sv/qfs_pkg.sv
package qfs_pkg;

    typedef enum logic [1:0] {
        RM_NEAREST = 2'd0,
        RM_ZERO    = 2'd1,
        RM_UP      = 2'd2,
        RM_DOWN    = 2'd3
    } round_mode_t;

    localparam logic ACT_QUICK = 1'b0;
    localparam logic ACT_EXCEPT = 1'b1;
    localparam logic [14:0] EXP_MAX = 15'h7fff;

    typedef struct packed {
        logic        action;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic signed [31:0] shift_count;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        inexact_flag;
    } out_item_t;

    // stage 1 -> stage 2
    typedef struct packed {
        logic        action;
        logic        sign;
        logic        passthru;     // result is operand unchanged
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [112:0] sig;         // normalized significand with hidden bit
        logic signed [34:0] texp;  // exact biased exponent + n (after norm)
        logic [31:0] nq;           // quick-mode add amount (n - s)
    } s1_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic        sign;
        logic        inf_res;
        logic        max_res;
        logic        tiny;
        logic        final_ok;
        logic [63:0] fin_high;
        logic [63:0] fin_low;
        logic [112:0] q;
        logic        guard;
        logic        sticky;
    } s2_t;

    function automatic logic [6:0] lzc113(input logic [112:0] v);
        logic [6:0] r;
        r = 7'd113;
        for (int i = 0; i < 113; i++) begin
            if (v[i]) begin
                r = 7'(112 - i);
            end
        end
        return r;
    endfunction

endpackage

### sv/quad_float_scale_by_power_of_two.sv
// Scales a binary128 value by 2^shift_count. Three-stage pipeline
// (normalize, exponent/shift, round): an accepted item passes through the
// normalize, shift and round registers in that order, and its result is
// then on the ports with done high; busy is never high, so an item may start in
// every cycle. The receiver cannot stall the results.
`include "quad_float_scale_by_power_of_two_macros.svh"
module quad_float_scale_by_power_of_two (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  qfs_pkg::in_item_t  in_item,
    output logic               done,
    output qfs_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata
);
    qfs_pkg::round_mode_t rmode_reg;
    logic         v1;
    logic         v2;
    qfs_pkg::s1_t s1;
    qfs_pkg::s2_t s2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmode_reg <= qfs_pkg::RM_NEAREST;
        end
        else if (cfg_we)
        begin
            rmode_reg <= qfs_pkg::round_mode_t'(cfg_wdata);
        end
    end

    assign busy = 1'b0;

    qfs_norm u_norm (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .item(in_item),
        .out_valid(v1), .s1(s1)
    );
    qfs_shift u_shift (
        .clk(clk), .rst_n(rst_n), .in_valid(v1), .s1(s1), .rmode(rmode_reg),
        .out_valid(v2), .s2(s2)
    );
    qfs_round u_round (
        .clk(clk), .rst_n(rst_n), .in_valid(v2), .s2(s2), .rmode(rmode_reg),
        .out_valid(done), .result(result)
    );

    `QFS_ASSERT_NEXT(a_lat1, clk, rst_n, start, v1, "stage 1 lost item")
    `QFS_ASSERT_NEXT(a_lat2, clk, rst_n, v1, v2, "stage 2 lost item")
    `QFS_ASSERT_NEXT(a_lat3, clk, rst_n, v2, done, "stage 3 lost item")
endmodule

### sv/qfs_norm.sv
module qfs_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qfs_pkg::in_item_t item,
    output logic              out_valid,
    output qfs_pkg::s1_t      s1
);
    logic         valid_reg;
    qfs_pkg::s1_t s1_reg;
    qfs_pkg::s1_t s1_next;
    logic [112:0] frac;
    logic [6:0]   lz;
    logic [6:0]   sh;
    logic [14:0]  e;
    logic         sub;

    always_comb
    begin
        e = item.value_high[62:48];
        frac = {1'b0, item.value_high[47:0], item.value_low};
        lz = qfs_pkg::lzc113(frac);
        sub = (e == 15'd0) && (item.action == qfs_pkg::ACT_QUICK);
        sh = sub ? lz : 7'd0;
        s1_next.action = item.action;
        s1_next.sign = item.value_high[63];
        s1_next.value_high = item.value_high;
        s1_next.value_low = item.value_low;
        s1_next.passthru = (e == 15'd0) &&
            ((item.action == qfs_pkg::ACT_EXCEPT) || (frac == 113'd0));
        s1_next.sig = sub ? (frac << sh) : {1'b1, item.value_high[47:0], item.value_low};
        s1_next.texp = 35'(signed'({20'd0, e})) + 35'(item.shift_count)
            + (sub ? 35'sd1 - 35'(signed'({28'd0, sh})) : 35'sd0);
        s1_next.nq = 32'(item.shift_count) - {25'd0, sh};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign out_valid = valid_reg;
    assign s1 = s1_reg;
endmodule

### sv/qfs_shift.sv
module qfs_shift (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  qfs_pkg::s1_t               s1,
    input  qfs_pkg::round_mode_t       rmode,
    output logic                       out_valid,
    output qfs_pkg::s2_t               s2
);
    logic         valid_reg;
    qfs_pkg::s2_t s2_reg;
    qfs_pkg::s2_t s2_next;
    logic [31:0]  top;
    logic [6:0]   k;
    logic [113:0] ext;
    logic [113:0] shifted;
    logic [113:0] mask;
    logic         to_inf;

    always_comb
    begin
        top = {s1.sign, 15'd1, s1.sig[111:96]} + {s1.nq[15:0], 16'd0};
        if (s1.value_high[62:48] != 15'd0)
        begin
            top = s1.value_high[63:32] + {s1.nq[15:0], 16'd0};
        end
        case (rmode)
            qfs_pkg::RM_NEAREST: to_inf = 1'b1;
            qfs_pkg::RM_ZERO:    to_inf = 1'b0;
            qfs_pkg::RM_UP:      to_inf = !s1.sign;
            qfs_pkg::RM_DOWN:    to_inf = s1.sign;
            default:             to_inf = 1'b1;
        endcase
        k = (s1.texp < -35'sd112) ? 7'd114 : 7'(35'sd1 - s1.texp);
        ext = {s1.sig, 1'b0};
        shifted = ext >> k;
        mask = ~({114{1'b1}} << k);
        s2_next.sign = s1.sign;
        s2_next.q = shifted[113:1];
        s2_next.guard = shifted[0];
        // bits below the guard bit; ext[0] is always zero
        s2_next.sticky = |(ext & mask);
        s2_next.inf_res = 1'b0;
        s2_next.max_res = 1'b0;
        s2_next.tiny = 1'b0;
        s2_next.final_ok = 1'b1;
        s2_next.fin_high = s1.value_high;
        s2_next.fin_low = s1.value_low;
        if (s1.passthru)
        begin
        end
        else if (s1.action == qfs_pkg::ACT_QUICK)
        begin
            if (s1.texp < 35'sd1)
            begin
                s2_next.fin_high = {s1.sign, 63'd0};
                s2_next.fin_low = 64'd0;
            end
            else
            begin
                s2_next.fin_high = {top, s1.sig[95:64]};
                s2_next.fin_low = s1.sig[63:0];
            end
        end
        else if (s1.texp >= 35'sd32767)
        begin
            s2_next.inf_res = to_inf;
            s2_next.max_res = !to_inf;
            s2_next.final_ok = 1'b0;
        end
        else if (s1.texp < 35'sd1)
        begin
            s2_next.tiny = 1'b1;
            s2_next.final_ok = 1'b0;
            if (s1.texp < -35'sd112)
            begin
                s2_next.guard = 1'b0;
                s2_next.sticky = 1'b1;
            end
        end
        else
        begin
            s2_next.fin_high = {s1.sign, s1.texp[14:0], s1.value_high[47:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign out_valid = valid_reg;
    assign s2 = s2_reg;
endmodule

### sv/qfs_round.sv
`include "quad_float_scale_by_power_of_two_macros.svh"
module qfs_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  qfs_pkg::s2_t         s2,
    input  qfs_pkg::round_mode_t rmode,
    output logic                 out_valid,
    output qfs_pkg::out_item_t   result
);
    logic               valid_reg;
    qfs_pkg::out_item_t res_reg;
    qfs_pkg::out_item_t res_next;
    logic               inx;
    logic               up;
    logic [112:0]       qr;

    always_comb
    begin
        inx = s2.guard || s2.sticky;
        case (rmode)
            qfs_pkg::RM_NEAREST: up = s2.guard && (s2.sticky || s2.q[0]);
            qfs_pkg::RM_ZERO:    up = 1'b0;
            qfs_pkg::RM_UP:      up = !s2.sign;
            qfs_pkg::RM_DOWN:    up = s2.sign;
            default:             up = 1'b0;
        endcase
        up = up && inx;
        qr = s2.q + {112'd0, up};
        res_next.result_high = s2.fin_high;
        res_next.result_low = s2.fin_low;
        res_next.overflow_flag = 1'b0;
        res_next.underflow_flag = 1'b0;
        res_next.inexact_flag = 1'b0;
        if (s2.inf_res)
        begin
            res_next.result_high = {s2.sign, qfs_pkg::EXP_MAX, 48'd0};
            res_next.result_low = 64'd0;
            res_next.overflow_flag = 1'b1;
            res_next.inexact_flag = 1'b1;
        end
        else if (s2.max_res)
        begin
            res_next.result_high = {s2.sign, 63'h7ffeffffffffffff};
            res_next.result_low = '1;
            res_next.overflow_flag = 1'b1;
            res_next.inexact_flag = 1'b1;
        end
        else if (s2.tiny)
        begin
            res_next.result_high = {s2.sign, 14'd0, qr[112:64]};
            res_next.result_low = qr[63:0];
            res_next.underflow_flag = inx;
            res_next.inexact_flag = inx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign result = res_reg;

    `QFS_ASSERT(a_ovf_inx, clk, rst_n,
        (valid_reg && res_reg.overflow_flag) |-> res_reg.inexact_flag, "overflow without inexact")
    `QFS_ASSERT(a_unf_inx, clk, rst_n,
        (valid_reg && res_reg.underflow_flag) |-> res_reg.inexact_flag, "underflow without inexact")
    `QFS_ASSERT(a_kind, clk, rst_n,
        in_valid |-> ($countones({s2.inf_res, s2.max_res, s2.tiny, s2.final_ok}) == 1),
        "stage kind")
endmodule

### sim/tb.sv
module tb;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               busy_q = 1'b0;
    qfs_pkg::in_item_t  in_item = '0;
    logic               done;
    qfs_pkg::out_item_t result;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_wdata = '0;

    quad_float_scale_by_power_of_two dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #1 clk = ~clk;

    qfs_pkg::in_item_t    pending_items[$];
    qfs_pkg::out_item_t   expected_scaled[$];
    qfs_pkg::round_mode_t scale_mode = qfs_pkg::RM_NEAREST;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          tiny_seen = 0;
    int          ovf_seen = 0;
    bit          calm = 1'b0;

    function automatic qfs_pkg::out_item_t scale_binary128(qfs_pkg::in_item_t it,
                                                           qfs_pkg::round_mode_t rm);
        qfs_pkg::out_item_t r;
        logic          sgn;
        logic [63:0]   hi;
        logic [63:0]   lo;
        logic [47:0]   fh;
        longint        e;
        longint        n;
        longint        t;
        int            p;
        int            s;
        int            k;
        logic [112:0]  sig;
        logic [112:0]  q;
        logic [112:0]  mask;
        logic [31:0]   top;
        logic          guard;
        logic          sticky;
        logic          up;
        logic          to_inf;
        r = '0;
        hi = it.value_high;
        lo = it.value_low;
        sgn = hi[63];
        e = hi[62:48];
        fh = hi[47:0];
        n = it.shift_count;
        if (it.action == qfs_pkg::ACT_QUICK) begin
            if (e == 0 && fh == 0 && lo == 0) begin
                r.result_high = hi;
                r.result_low = lo;
                return r;
            end
            if (e == 0) begin
                sig = {1'b0, fh, lo};
                p = 0;
                for (int i = 0; i < 113; i++)
                    if (sig[i]) p = i;
                s = 112 - p;
                sig = sig << s;
                hi = {sgn, 15'd1, sig[111:64]};
                lo = sig[63:0];
                e = 1;
                n = n - s;
            end
            if (e + n < 1) begin
                hi = {sgn, 63'd0};
                lo = '0;
            end else begin
                top = hi[63:32] + (32'(n) << 16);
                hi = {top, hi[31:0]};
            end
        end else if (e != 0) begin
            t = e + n;
            if (t >= 32767) begin
                case (rm)
                    qfs_pkg::RM_NEAREST: to_inf = 1'b1;
                    qfs_pkg::RM_ZERO:    to_inf = 1'b0;
                    qfs_pkg::RM_UP:      to_inf = !sgn;
                    default:             to_inf = sgn;
                endcase
                if (to_inf) begin
                    hi = {sgn, 15'h7fff, 48'd0};
                    lo = '0;
                end else begin
                    hi = {sgn, 63'h7ffeffffffffffff};
                    lo = '1;
                end
                r.overflow_flag = 1'b1;
                r.inexact_flag = 1'b1;
            end else if (t < 1) begin
                sig = {1'b1, fh, lo};
                if (t < -112) begin
                    q = '0;
                    guard = 1'b0;
                    sticky = 1'b1;
                end else begin
                    k = 1 - t;
                    guard = sig[k - 1];
                    mask = (113'd1 << (k - 1)) - 113'd1;
                    sticky = (sig & mask) != 0;
                    q = sig >> k;
                end
                up = 1'b0;
                if (guard || sticky) begin
                    case (rm)
                        qfs_pkg::RM_NEAREST: up = guard && (sticky || q[0]);
                        qfs_pkg::RM_UP:      up = !sgn;
                        qfs_pkg::RM_DOWN:    up = sgn;
                        default:             up = 1'b0;
                    endcase
                    r.underflow_flag = 1'b1;
                    r.inexact_flag = 1'b1;
                end
                if (up) q = q + 113'd1;
                hi = {sgn, 14'd0, q[112:64]};
                lo = q[63:0];
            end else begin
                hi = {sgn, 15'(t), fh};
            end
        end
        r.result_high = hi;
        r.result_low = lo;
        return r;
    endfunction

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!(start && busy_q)) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
                    in_item <= pending_items.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) busy_q <= busy;

    // monitor
    always @(posedge clk) begin
        qfs_pkg::out_item_t want;
        if (rst_n && start && !busy) begin
            expected_scaled.push_back(scale_binary128(in_item, scale_mode));
            items_sent++;
        end
        if (rst_n && done) begin
            results_seen++;
            if (expected_scaled.size() == 0) begin
                $display("%0t: result with nothing pending: %h", $time, result);
                mismatches++;
            end else begin
                want = expected_scaled.pop_front();
                if (want.underflow_flag) tiny_seen++;
                if (want.overflow_flag) ovf_seen++;
                if (result !== want) begin
                    $display("%0t: mismatch expected %h_%h %b%b%b actual %h_%h %b%b%b",
                        $time, want.result_high, want.result_low, want.overflow_flag,
                        want.underflow_flag, want.inexact_flag, result.result_high,
                        result.result_low, result.overflow_flag, result.underflow_flag,
                        result.inexact_flag);
                    mismatches++;
                end
            end
        end
    end

    function automatic qfs_pkg::in_item_t rand_item();
        qfs_pkg::in_item_t it;
        int       kind;
        it.action = 1'($urandom_range(1));
        it.value_high = {$urandom, $urandom};
        it.value_low = {$urandom, $urandom};
        it.shift_count = $urandom;
        kind = $urandom_range(9);
        case (kind)
            0: it.value_high[62:48] = '0;
            1: it.value_high[62:48] = '1;
            2: it.shift_count = 32'($signed($urandom_range(300)) - 150);
            3: it.shift_count = 32'(-int'(it.value_high[62:48])
                   - int'($urandom_range(120)));
            4: it.shift_count = 32'(32767 - int'(it.value_high[62:48])
                   - int'($urandom_range(3)));
            5: begin
                it.value_high[62:0] = {15'd0, 48'd0} | ($urandom_range(1) ?
                    63'({$urandom, $urandom} >> $urandom_range(63)) : 63'd0);
                it.value_low = {$urandom, $urandom} >> $urandom_range(63);
                it.value_high[62:48] = '0;
                it.shift_count = 32'($signed($urandom_range(400)) - 200);
            end
            6: it.shift_count = 32'($signed($urandom_range(40000)) - 20000);
            default: ;
        endcase
        return it;
    endfunction

    task automatic push_dir(logic act, logic [63:0] h, logic [63:0] l, int n);
        qfs_pkg::in_item_t it;
        it.action = act;
        it.value_high = h;
        it.value_low = l;
        it.shift_count = n;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (start || expected_scaled.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_mode(qfs_pkg::round_mode_t rm);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= rm;
        @(negedge clk);
        cfg_we <= 1'b0;
        scale_mode = rm;
    endtask

    initial begin
        qfs_pkg::round_mode_t modes[6];
        modes = '{qfs_pkg::RM_NEAREST, qfs_pkg::RM_ZERO, qfs_pkg::RM_UP,
                  qfs_pkg::RM_DOWN, qfs_pkg::RM_NEAREST, qfs_pkg::RM_DOWN};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        push_dir(qfs_pkg::ACT_QUICK, 64'h0, 64'h0, 5);
        push_dir(qfs_pkg::ACT_QUICK, 64'h8000000000000000, 64'h0, -5);
        push_dir(qfs_pkg::ACT_QUICK, 64'h0, 64'h1, 200);
        push_dir(qfs_pkg::ACT_QUICK, 64'h8000ffffffffffff, 64'hffffffffffffffff, -3);
        push_dir(qfs_pkg::ACT_QUICK, 64'h3fff000000000000, 64'h0, -16383);
        push_dir(qfs_pkg::ACT_QUICK, 64'h7ffe123456789abc, 64'h1, 2);
        push_dir(qfs_pkg::ACT_QUICK, 64'h7fff000000000000, 64'h0, 32'h7fffffff);
        push_dir(qfs_pkg::ACT_QUICK, 64'hffffffffffffffff, '1, 32'h80000000);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h0000123400000000, 64'h5, 100);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h7fff000000000000, 64'h0, 0);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'hfffe000000000000, 64'h0, 1);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h3fff000000000000, 64'h0, 32'h7fffffff);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h3fff000000000000, 64'h0, -16383);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'hbfffffffffffffff, '1, -16495);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h3fff000000000000, 64'h1, -16496);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h0001ffffffffffff, '1, -1);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h8001000000000000, 64'h0, 32'h80000000);
        push_dir(qfs_pkg::ACT_EXCEPT, 64'h4000000000000000, 64'h1, -16385);
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            set_mode(modes[ph]);
            if (ph > 0) calm = (ph == 3);
            for (int i = 0; i < (ph == 0 ? 30 : 245); i++)
                pending_items.push_back(rand_item());
            if (ph == 0)
                for (int i = 0; i < 18; i++) pending_items.push_back(pending_items[i]);
        end
        drain();
        $display("run covered %0d items, %0d results, over all rounding modes",
            items_sent, results_seen);
        $display("including %0d overflows and %0d inexact tiny results", ovf_seen, tiny_seen);
        if (mismatches == 0 && expected_scaled.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/qfs_pkg.sv
sv/qfs_norm.sv
sv/qfs_shift.sv
sv/qfs_round.sv
sv/quad_float_scale_by_power_of_two.sv
sim/tb.sv
